@@ rtl/stl_pkg.sv @@
// ----------------------------------------------------------------------------
// stl_pkg
// Shared constants, types and helpers for the symbol table core.
// ----------------------------------------------------------------------------
package stl_pkg;

	localparam int SYMBOLS    = 256;
	localparam int NAME_CHARS = 63;
	localparam int SLOT_W     = $clog2(SYMBOLS);
	localparam int CNT_W      = $clog2(SYMBOLS + 1);
	localparam int LEN_W      = $clog2(NAME_CHARS + 1);
	localparam int NS_AW      = SLOT_W + LEN_W;
	localparam int ADDR_W     = 32;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_T_LO  = 8'h74;
	localparam logic [7:0] CH_T_UP  = 8'h54;
	localparam logic [3:0] ADDR_COLS = 4'd8;

	typedef struct packed {
		logic              ins;    // line ended with a text symbol to store
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  len;
	} stl_line_t;

	typedef struct packed {
		logic              le;
		logic              valid;
		logic [ADDR_W-1:0] addr;
		logic [SLOT_W-1:0] slot;
	} stl_link_t;

	// bit 4 set: hex digit in bits 3:0
	function automatic logic [4:0] hex_digit(input logic [7:0] ch);
		logic [4:0] r;
		r = 5'd0;
		if (ch >= 8'h30 && ch <= 8'h39) r = {1'b1, 4'(ch - 8'h30)};
		else if (ch >= 8'h61 && ch <= 8'h66) r = {1'b1, 4'(ch - 8'h57)};
		else if (ch >= 8'h41 && ch <= 8'h46) r = {1'b1, 4'(ch - 8'h37)};
		return r;
	endfunction

endpackage

@@ rtl/stl_if.sv @@
// ----------------------------------------------------------------------------
// stl_in_if / stl_out_if
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface stl_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [7:0]  text_char;
	logic [31:0] lookup_address;
	modport source (output valid, action, text_char, lookup_address, input ready);
	modport sink   (input valid, action, text_char, lookup_address, output ready);
endinterface

interface stl_out_if;
	logic       valid;
	logic       ready;
	logic       found;
	logic [7:0] name_char;
	logic       last;
	logic [8:0] symbol_total;
	logic       overflow;
	modport source (output valid, found, name_char, last, symbol_total, overflow, input ready);
	modport sink   (input valid, found, name_char, last, symbol_total, overflow, output ready);
endinterface

@@ rtl/stl_cell.sv @@
// ----------------------------------------------------------------------------
// stl_cell
// One entry of the sorted table: compares against the key, shifts on insert.
// ----------------------------------------------------------------------------
module stl_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [stl_pkg::ADDR_W-1:0] key,
	input  logic                      ins,
	input  logic [stl_pkg::SLOT_W-1:0] new_slot,
	input  stl_pkg::stl_link_t        prev,
	output stl_pkg::stl_link_t        self
);
	import stl_pkg::*;

	logic              valid_q;
	logic [ADDR_W-1:0] addr_q;
	logic [SLOT_W-1:0] slot_q;
	logic              le;

	assign le = valid_q && (addr_q <= key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ins && !le) begin
			valid_q <= prev.le ? 1'b1 : prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ins && !le) begin
			// boundary cell takes the new entry, cells above shift up by one
			addr_q <= prev.le ? key : prev.addr;
			slot_q <= prev.le ? new_slot : prev.slot;
		end
	end

	assign self = '{le: le, valid: valid_q, addr: addr_q, slot: slot_q};
endmodule

@@ rtl/stl_parser.sv @@
// ----------------------------------------------------------------------------
// stl_parser
// Line parser for symbol text; holds the name of the current line.
// ----------------------------------------------------------------------------
module stl_parser (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     take,
	input  logic [7:0]               ch,
	input  logic [stl_pkg::LEN_W-1:0] rd_addr,
	output logic [7:0]               rd_data,
	output stl_pkg::stl_line_t       line
);
	import stl_pkg::*;

	typedef enum logic [2:0] {
		PH_START, PH_ADDR, PH_PRE_TYPE, PH_POST_TYPE, PH_NAME, PH_DISCARD
	} phase_t;

	phase_t            phase_q;
	logic [3:0]        column_q;
	logic [ADDR_W-1:0] hex_q;
	logic              stopped_q;
	logic              is_text_q;
	logic [LEN_W-1:0]  len_q;
	logic [7:0]        name_mem [NAME_CHARS];

	logic       line_end;
	logic [4:0] hd;
	logic       store;

	assign line_end = (ch == CH_NL) || (ch == CH_NUL);
	assign hd       = hex_digit(ch);
	assign store    = take && !line_end && len_q < LEN_W'(NAME_CHARS) &&
		(phase_q == PH_NAME || (phase_q == PH_POST_TYPE && ch != CH_SPACE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			column_q  <= '0;
			hex_q     <= '0;
			stopped_q <= 1'b0;
			is_text_q <= 1'b0;
			len_q     <= '0;
		end else if (take) begin
			if (line_end) begin
				phase_q  <= PH_START;
				column_q <= '0;
			end else begin
				if (store) len_q <= len_q + 1'b1;
				unique case (phase_q)
					PH_START: begin
						if (hd[4]) begin
							hex_q     <= ADDR_W'(hd[3:0]);
							stopped_q <= 1'b0;
							column_q  <= 4'd1;
							phase_q   <= PH_ADDR;
						end else begin
							phase_q <= PH_DISCARD;
						end
					end
					PH_ADDR: begin
						if (!stopped_q && hd[4]) hex_q <= {hex_q[ADDR_W-5:0], hd[3:0]};
						else stopped_q <= 1'b1;
						column_q <= column_q + 1'b1;
						if (column_q + 1'b1 >= ADDR_COLS) phase_q <= PH_PRE_TYPE;
					end
					PH_PRE_TYPE: begin
						if (ch != CH_SPACE) begin
							is_text_q <= (ch == CH_T_LO) || (ch == CH_T_UP);
							len_q     <= '0;
							phase_q   <= PH_POST_TYPE;
						end
					end
					PH_POST_TYPE: begin
						if (ch != CH_SPACE) phase_q <= PH_NAME;
					end
					PH_NAME, PH_DISCARD: ;
					default: phase_q <= PH_START;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store) name_mem[len_q] <= ch;
		rd_data <= name_mem[rd_addr];
	end

	assign line.ins  = take && line_end && phase_q == PH_NAME && is_text_q && len_q != '0;
	assign line.addr = hex_q;
	assign line.len  = len_q;
endmodule

@@ rtl/symbol_table_parse_and_lookup_core.sv @@
// Text byte: taken in S_IDLE; a stored symbol then passes S_INS and copies its name,
// one byte per S_CP_RD/S_CP_WR pair through the name memory ports.
// Lookup: S_LK_SEL, S_LK_LEN, S_LK_K, then S_RD and S_EMIT per name byte; a
// miss goes to S_MISS. S_EMIT and S_MISS hold while the result is not taken.
// One request in flight at a time; the result register decouples the output.
// Reset clears the parser, count, overflow and cell valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// symbol_table_parse_and_lookup_core
// Parses symbol text into a sorted chain of cells and resolves lookups.
// ----------------------------------------------------------------------------
module symbol_table_parse_and_lookup_core (
	input  logic            clk,
	input  logic            arst_n,
	stl_in_if.sink          req_in,
	stl_out_if.source       rsp_out
);
	import stl_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_INS, S_CP_RD, S_CP_WR, S_LK_SEL, S_LK_LEN, S_LK_K, S_RD, S_EMIT, S_MISS
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic              ovf_q;
	logic [ADDR_W-1:0] key_q;
	logic [SLOT_W-1:0] slot_q;
	logic [LEN_W-1:0]  k_q;
	logic [LEN_W-1:0]  len_q;

	logic              ov_q;
	logic              found_q;
	logic [7:0]        char_q;
	logic              last_q;
	logic [CNT_W-1:0]  tot_q;
	logic              ovo_q;

	logic              take_text;
	logic              space;
	logic              emit;
	stl_line_t         line;
	logic [7:0]        ln_rd;
	logic [ADDR_W-1:0] key;
	logic              ins;

	logic [7:0]        name_store [2**NS_AW];
	logic [LEN_W-1:0]  name_length [SYMBOLS];
	logic [7:0]        ns_rd;
	logic [LEN_W-1:0]  nl_rd;

	stl_link_t         link [SYMBOLS+1];
	logic [SYMBOLS-1:0] bound;
	logic [SLOT_W-1:0] sel_slot;

	assign req_in.ready = (state_q == S_IDLE);
	assign take_text    = req_in.valid && req_in.ready && !req_in.action;
	assign space        = !ov_q || rsp_out.ready;
	assign emit         = space && (state_q == S_EMIT || state_q == S_MISS);
	assign ins          = (state_q == S_INS);
	assign key          = ins ? line.addr : key_q;

	stl_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take_text),
		.ch      (req_in.text_char),
		.rd_addr (k_q),
		.rd_data (ln_rd),
		.line    (line)
	);

	// head of the chain: a virtual entry below every address
	assign link[0] = '{le: 1'b1, valid: 1'b1, addr: '0, slot: '0};

	for (genvar i = 0; i < SYMBOLS; i++) begin : g_cell
		stl_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.key      (key),
			.ins      (ins),
			.new_slot (count_q[SLOT_W-1:0]),
			.prev     (link[i]),
			.self     (link[i+1])
		);
		if (i == SYMBOLS - 1) begin : g_top
			assign bound[i] = link[i+1].le;
		end else begin : g_mid
			assign bound[i] = link[i+1].le && !link[i+2].le;
		end
	end

	always_comb begin
		sel_slot = '0;
		for (int i = 0; i < SYMBOLS; i++) begin
			sel_slot = sel_slot | (link[i+1].slot & {SLOT_W{bound[i]}});
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_INS) name_length[count_q[SLOT_W-1:0]] <= line.len;
		if (state_q == S_CP_WR) name_store[{slot_q, k_q}] <= ln_rd;
		nl_rd <= name_length[slot_q];
		ns_rd <= name_store[{slot_q, k_q}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ovf_q   <= 1'b0;
			ov_q    <= 1'b0;
			key_q   <= '0;
			slot_q  <= '0;
			k_q     <= '0;
			len_q   <= '0;
			found_q <= 1'b0;
			char_q  <= '0;
			last_q  <= 1'b0;
			tot_q   <= '0;
			ovo_q   <= 1'b0;
		end else begin
			if (rsp_out.ready && !emit) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req_in.valid) begin
						if (req_in.action) begin
							key_q   <= req_in.lookup_address;
							state_q <= S_LK_SEL;
						end else if (line.ins) begin
							if (count_q >= CNT_W'(SYMBOLS)) ovf_q <= 1'b1;
							else state_q <= S_INS;
						end
					end
				end
				S_INS: begin
					slot_q  <= count_q[SLOT_W-1:0];
					len_q   <= line.len;
					k_q     <= '0;
					state_q <= S_CP_RD;
				end
				S_CP_RD: state_q <= S_CP_WR;
				S_CP_WR: begin
					if (k_q + 1'b1 == len_q) begin
						count_q <= count_q + 1'b1;
						state_q <= S_IDLE;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_CP_RD;
					end
				end
				S_LK_SEL: begin
					slot_q  <= sel_slot;
					state_q <= link[1].le ? S_LK_LEN : S_MISS;
				end
				S_LK_LEN: state_q <= S_LK_K;
				S_LK_K: begin
					len_q   <= (nl_rd == '0) ? LEN_W'(1) : nl_rd;
					k_q     <= '0;
					state_q <= S_RD;
				end
				S_RD: state_q <= S_EMIT;
				S_EMIT: begin
					if (space) begin
						ov_q    <= 1'b1;
						found_q <= 1'b1;
						char_q  <= ns_rd;
						last_q  <= (k_q + 1'b1 == len_q);
						tot_q   <= count_q;
						ovo_q   <= ovf_q;
						if (k_q + 1'b1 == len_q) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				S_MISS: begin
					if (space) begin
						ov_q    <= 1'b1;
						found_q <= 1'b0;
						char_q  <= '0;
						last_q  <= 1'b1;
						tot_q   <= count_q;
						ovo_q   <= ovf_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_out.valid        = ov_q;
	assign rsp_out.found        = found_q;
	assign rsp_out.name_char    = char_q;
	assign rsp_out.last         = last_q;
	assign rsp_out.symbol_total = tot_q;
	assign rsp_out.overflow     = ovo_q;
endmodule

@@ tb/stl_checker.sv @@
// ----------------------------------------------------------------------------
// stl_checker
// Watches the request and result channels, parses the accepted symbol text
// into its own sorted table and compares every lookup result with it.
// ----------------------------------------------------------------------------
module stl_checker (
	input  logic     clk,
	input  logic     arst_n,
	stl_in_if.sink   req_mon,
	stl_out_if.sink  rsp_mon,
	output int       fail_count,
	output int       pending,
	output int       lookups_seen,
	output int       results_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import stl_pkg::*;

	typedef enum logic [2:0] {
		LN_START, LN_ADDR, LN_PRE_TYPE, LN_POST_TYPE, LN_NAME, LN_DISCARD
	} line_phase_e;

	typedef struct packed {
		logic       found;
		logic [7:0] name_char;
		logic       last;
		logic [8:0] symbol_total;
		logic       overflow;
	} name_beat_t;

	logic [31:0] tbl_addr [SYMBOLS];
	logic [7:0]  tbl_name [SYMBOLS][NAME_CHARS];
	int          tbl_len  [SYMBOLS];
	int          tbl_count;
	logic        ovf;
	line_phase_e phase;
	int          col;
	logic [31:0] hexv;
	logic        hex_stop;
	logic        is_text;
	logic [7:0]  cur_name [NAME_CHARS];
	int          cur_len;
	name_beat_t  expected_beats [$];

	function automatic int hexval(logic [7:0] ch);
		if (ch >= "0" && ch <= "9") return ch - "0";
		if (ch >= "a" && ch <= "f") return ch - "a" + 10;
		if (ch >= "A" && ch <= "F") return ch - "A" + 10;
		return -1;
	endfunction

	function automatic int first_above(logic [31:0] key);
		int i;
		i = 0;
		while (i < tbl_count && tbl_addr[i] <= key) i++;
		return i;
	endfunction

	task automatic store_line();
		int pos;
		if (tbl_count >= SYMBOLS) begin
			ovf = 1'b1;
			return;
		end
		pos = first_above(hexv);
		for (int i = tbl_count; i > pos; i--) begin
			tbl_addr[i] = tbl_addr[i-1];
			tbl_name[i] = tbl_name[i-1];
			tbl_len[i]  = tbl_len[i-1];
		end
		tbl_addr[pos] = hexv;
		tbl_name[pos] = cur_name;
		tbl_len[pos]  = cur_len;
		tbl_count++;
	endtask

	task automatic parse_char(logic [7:0] ch);
		int d;
		d = hexval(ch);
		if (ch == CH_NL || ch == CH_NUL) begin
			if (phase == LN_NAME && is_text && cur_len > 0) store_line();
			phase = LN_START;
			col = 0;
			return;
		end
		case (phase)
			LN_START: begin
				if (d >= 0) begin
					hexv = 32'(d); hex_stop = 0; col = 1; phase = LN_ADDR;
				end else phase = LN_DISCARD;
			end
			LN_ADDR: begin
				if (!hex_stop && d >= 0) hexv = {hexv[27:0], 4'(d)};
				else hex_stop = 1;
				col++;
				if (col >= 8) phase = LN_PRE_TYPE;
			end
			LN_PRE_TYPE: begin
				if (ch != CH_SPACE) begin
					is_text = (ch == CH_T_LO || ch == CH_T_UP);
					cur_len = 0;
					phase = LN_POST_TYPE;
				end
			end
			LN_POST_TYPE, LN_NAME: begin
				if (!(phase == LN_POST_TYPE && ch == CH_SPACE)) begin
					phase = LN_NAME;
					if (cur_len < NAME_CHARS) begin
						cur_name[cur_len] = ch;
						cur_len++;
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic predict_lookup(logic [31:0] key);
		int u, n;
		name_beat_t b;
		u = first_above(key);
		b.symbol_total = 9'(tbl_count);
		b.overflow = ovf;
		if (u == 0) begin
			b.found = 0; b.name_char = 0; b.last = 1;
			expected_beats.push_back(b);
			return;
		end
		n = tbl_len[u-1];
		for (int k = 0; k < n; k++) begin
			b.found = 1;
			b.name_char = tbl_name[u-1][k];
			b.last = (k == n - 1);
			expected_beats.push_back(b);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		name_beat_t e;
		if (!arst_n) begin
			tbl_count = 0; ovf = 0; phase = LN_START; col = 0; hexv = 0;
			hex_stop = 0; is_text = 0; cur_len = 0;
			fail_count = 0; lookups_seen = 0; results_seen = 0;
			expected_beats.delete();
			pending = 0;
		end else begin
			if (rsp_mon.valid && rsp_mon.ready) begin
				results_seen++;
				if (expected_beats.size() == 0) begin
					$error("unexpected result name_char=%0h", rsp_mon.name_char);
					fail_count++;
				end else begin
					e = expected_beats.pop_front();
					if (rsp_mon.found !== e.found) begin
						$error("found exp %0h act %0h", e.found, rsp_mon.found);
						fail_count++;
					end
					if (rsp_mon.name_char !== e.name_char) begin
						$error("name_char exp %0h act %0h", e.name_char, rsp_mon.name_char);
						fail_count++;
					end
					if (rsp_mon.last !== e.last) begin
						$error("last exp %0h act %0h", e.last, rsp_mon.last);
						fail_count++;
					end
					if (rsp_mon.symbol_total !== e.symbol_total) begin
						$error("symbol_total exp %0d act %0d", e.symbol_total,
							rsp_mon.symbol_total);
						fail_count++;
					end
					if (rsp_mon.overflow !== e.overflow) begin
						$error("overflow exp %0h act %0h", e.overflow, rsp_mon.overflow);
						fail_count++;
					end
				end
			end
			if (req_mon.valid && req_mon.ready) begin
				if (req_mon.action) begin
					lookups_seen++;
					predict_lookup(req_mon.lookup_address);
				end else parse_char(req_mon.text_char);
			end
			pending = expected_beats.size();
		end
	end
endmodule

@@ tb/symbol_table_parse_and_lookup_core_tb.sv @@
// ----------------------------------------------------------------------------
// symbol_table_parse_and_lookup_core_tb
// Feeds symbol-list text and lookup requests with bursty valid and a
// stalling receiver; the checker predicts and compares every name byte.
// ----------------------------------------------------------------------------
module symbol_table_parse_and_lookup_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	int   fail_count, pending, lookups_seen, results_seen;
	int   cycles;
	int   burst_left;
	int   items_sent;
	logic [31:0] known_addr [$];

	stl_in_if  req_in();
	stl_out_if rsp_out();

	symbol_table_parse_and_lookup_core u_dut (
		.clk(clk), .arst_n(arst_n), .req_in(req_in.sink), .rsp_out(rsp_out.source)
	);

	stl_checker u_chk (
		.clk(clk), .arst_n(arst_n), .req_mon(req_in.sink), .rsp_mon(rsp_out.sink),
		.fail_count(fail_count), .pending(pending),
		.lookups_seen(lookups_seen), .results_seen(results_seen)
	);

	initial clk = 0;
	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("symbol_table_parse_and_lookup_core_tb NOT OK");
			$finish;
		end
	end

	// receiver stall pattern: long open stretches, then random stalls
	always @(posedge clk) begin
		if (((cycles / 512) % 3) == 0) rsp_out.ready <= 1'b1;
		else rsp_out.ready <= ($urandom_range(0, 3) != 0);
	end

	task automatic send(logic act, logic [7:0] ch, logic [31:0] key);
		if (burst_left == 0) begin
			req_in.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 20);
		end
		req_in.valid <= 1'b1;
		req_in.action <= act;
		req_in.text_char <= ch;
		req_in.lookup_address <= key;
		@(posedge clk);
		while (!req_in.ready) @(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send(1'b0, s[i], $urandom);
	endtask

	task automatic lookup(logic [31:0] key);
		send(1'b1, 8'($urandom), key);
	endtask

	function automatic string hex8(logic [31:0] a);
		return $sformatf("%08x", a);
	endfunction

	function automatic string rand_name(int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(33, 126)))};
		return s;
	endfunction

	task automatic wait_drain();
		req_in.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	initial begin
		logic [31:0] a;
		int r;
		cycles = 0; burst_left = 0; items_sent = 0;
		arst_n = 0;
		req_in.valid = 0; req_in.action = 0; req_in.text_char = 0;
		req_in.lookup_address = 0; rsp_out.ready = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty table, short address, NUL end, skipped lines, long name
		lookup(32'h0);
		send_text("1000    T f\n");
		send_text("ffffffffta");
		send(1'b0, 8'h00, 32'h0);
		send_text("12 T\n");
		send_text("zz\n");
		send_text("00002000Dd\n");
		send_text("00003000 \n");
		send_text({"0000aBcDT", rand_name(64), "\n"});
		lookup(32'hFFFF_FFFF);
		lookup(32'h0000_0FFF);
		lookup(32'h0000_1000);
		wait_drain();

		// random: short well-formed lines with noise, lookups mixed in
		while (items_sent < 150) begin
			r = $urandom_range(0, 9);
			a = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 64);
			if (r < 4) begin
				send_text({hex8(a), ($urandom_range(0, 1) ? "t" : "T"),
					rand_name($urandom_range(1, 3)), "\n"});
				known_addr.push_back(a);
			end else if (r < 8) begin
				if (known_addr.size() != 0 && $urandom_range(0, 1))
					a = known_addr[$urandom_range(0, known_addr.size() - 1)]
						+ $urandom_range(0, 1) - 1;
				lookup(a);
			end else if (r == 8) begin
				send(1'b0, 8'($urandom), $urandom);
			end else begin
				send_text({hex8(a), "Bx\n"});
			end
		end

		req_in.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("covered %0d requests, %0d lookups, %0d result beats",
			items_sent, lookups_seen, results_seen);
		if (fail_count == 0) $display("symbol_table_parse_and_lookup_core_tb OK");
		else $display("symbol_table_parse_and_lookup_core_tb NOT OK");
		$finish;
	end
endmodule

@@ symbol_table_parse_and_lookup_core.f @@
rtl/stl_pkg.sv
rtl/stl_if.sv
rtl/stl_cell.sv
rtl/stl_parser.sv
rtl/symbol_table_parse_and_lookup_core.sv
tb/stl_checker.sv
tb/symbol_table_parse_and_lookup_core_tb.sv
